/* hw/rtl/sfr_pkg.sv */
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the sensor frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int BYTE_W       = 8;
	localparam int LEN_W        = 7;
	localparam int MAX_BODY_DEF = 64;
	localparam int PADDR_W      = 4;
	localparam int PDATA_W      = 32;

	localparam logic [BYTE_W-1:0] START_CODE_RST = 8'd73;
	localparam logic [BYTE_W-1:0] END_CODE_RST   = 8'd77;
	localparam logic [LEN_W-1:0]  MAX_LENGTH_RST = 7'd64;
	localparam logic [BYTE_W-1:0] BROADCAST_ADDR = 8'hff;

	typedef enum logic [1:0] {
		REG_START_CODE = 2'd0,
		REG_END_CODE   = 2'd1,
		REG_MAX_LENGTH = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_HUNT,
		ST_ADDR,
		ST_LEN,
		ST_BODY,
		ST_SUM,
		ST_END,
		ST_RD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_code;
		logic [BYTE_W-1:0] end_code;
		logic [LEN_W-1:0]  max_length;
	} cfg_t;

	typedef struct packed {
		logic eq;
		logic gt;
	} alu_flags_t;

endpackage

/* hw/rtl/sfr_ram.sv */
// ----------------------------------------------------------------------------
// sfr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/sfr_alu.sv */
// ----------------------------------------------------------------------------
// sfr_alu
// Shared byte unit: modulo-256 accumulate plus equal / greater compare.
// ----------------------------------------------------------------------------
module sfr_alu (
	input  logic [sfr_pkg::BYTE_W-1:0] acc,
	input  logic [sfr_pkg::BYTE_W-1:0] ref_val,
	input  logic [sfr_pkg::BYTE_W-1:0] operand,
	output logic [sfr_pkg::BYTE_W-1:0] sum,
	output sfr_pkg::alu_flags_t        flags
);
	import sfr_pkg::*;

	assign sum      = acc + operand;
	assign flags.eq = (operand == ref_val);
	assign flags.gt = (operand > ref_val);

endmodule

/* hw/rtl/sfr_cfg.sv */
// ----------------------------------------------------------------------------
// sfr_cfg
// APB register file: start code, end code, max body length.
// ----------------------------------------------------------------------------
module sfr_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sfr_pkg::PADDR_W-1:0] paddr,
	input  logic [sfr_pkg::PDATA_W-1:0] pwdata,
	output logic [sfr_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output sfr_pkg::cfg_t               cfg
);
	import sfr_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_code <= START_CODE_RST;
			cfg_q.end_code   <= END_CODE_RST;
			cfg_q.max_length <= MAX_LENGTH_RST;
		end else if (wr_en) begin
			case (idx)
				REG_START_CODE: cfg_q.start_code <= pwdata[BYTE_W-1:0];
				REG_END_CODE:   cfg_q.end_code   <= pwdata[BYTE_W-1:0];
				REG_MAX_LENGTH: cfg_q.max_length <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_START_CODE: prdata = PDATA_W'(cfg_q.start_code);
			REG_END_CODE:   prdata = PDATA_W'(cfg_q.end_code);
			REG_MAX_LENGTH: prdata = PDATA_W'(cfg_q.max_length);
			default:        prdata = '0;
		endcase
	end

endmodule

/* hw/rtl/sensor_frame_receiver.sv */
// ----------------------------------------------------------------------------
// sensor_frame_receiver
// Frame parser (start, address, length, body, checksum, end) with a body
// store; a valid frame is replayed as one beat per body byte.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  in       | in_valid / in_ready    | rx_byte
//  out      | out_valid / out_ready  | frame_address, body_length, body_byte, last
//  cfg      | psel/penable/pwrite    | paddr, pwdata, prdata (pready tied high)
//
// while parsing, in_ready stays high and a byte is taken whenever in_valid is high
// after a good end code the body is replayed beat by beat (store read, then
// output load), and in_ready stays low until the last beat has been loaded
// the single shared byte unit does all checksum adds and code compares
// reset clears the parser to hunting and sets the registers to their defaults
// a stalled output holds its beat; the next beat waits for the output register
module sensor_frame_receiver #(
	parameter int MAX_BODY = sfr_pkg::MAX_BODY_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [sfr_pkg::PADDR_W-1:0] paddr,
	input  logic [sfr_pkg::PDATA_W-1:0] pwdata,
	output logic [sfr_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [sfr_pkg::BYTE_W-1:0]  rx_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sfr_pkg::BYTE_W-1:0]  frame_address,
	output logic [sfr_pkg::LEN_W-1:0]   body_length,
	output logic [sfr_pkg::BYTE_W-1:0]  body_byte,
	output logic                        last
);
	import sfr_pkg::*;

	localparam int AW = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
	localparam int CW = $clog2(MAX_BODY + 1);
	localparam logic [LEN_W-1:0] BODY_LIM = LEN_W'(MAX_BODY);

	cfg_t       cfg;
	state_t     state_q, state_d;
	alu_flags_t flags;

	logic [BYTE_W-1:0] sum_q, alu_sum, alu_ref;
	logic [CW-1:0]     cnt_q, cnt_nxt, rd_q, rd_nxt;
	logic [LEN_W-1:0]  exp_q, len_lim;
	logic [BYTE_W-1:0] addr_q;
	logic [BYTE_W-1:0] ram_rdata;
	logic              acc_in, body_wr, len_bad, body_done, rd_last, ld_out;
	logic              out_valid_q, last_q;
	logic [BYTE_W-1:0] out_addr_q, out_byte_q;
	logic [LEN_W-1:0]  out_len_q;

	sfr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the limit saturates at the store depth
	assign len_lim = (cfg.max_length > BODY_LIM) ? BODY_LIM : cfg.max_length;

	always_comb begin
		case (state_q)
			ST_HUNT: alu_ref = cfg.start_code;
			ST_ADDR: alu_ref = BROADCAST_ADDR;
			ST_LEN:  alu_ref = BYTE_W'(len_lim);
			ST_SUM:  alu_ref = sum_q;
			ST_END:  alu_ref = cfg.end_code;
			default: alu_ref = '0;
		endcase
	end

	sfr_alu u_alu (
		.acc     (sum_q),
		.ref_val (alu_ref),
		.operand (rx_byte),
		.sum     (alu_sum),
		.flags   (flags)
	);

	assign in_ready  = (state_q != ST_RD) && (state_q != ST_EMIT);
	assign acc_in    = in_valid && in_ready;
	assign cnt_nxt   = cnt_q + 1'b1;
	assign rd_nxt    = rd_q + 1'b1;
	assign len_bad   = (rx_byte == '0) || flags.gt;
	assign body_done = (LEN_W'(cnt_nxt) == exp_q);
	assign rd_last   = (LEN_W'(rd_nxt) == exp_q);
	assign body_wr   = acc_in && (state_q == ST_BODY);
	assign ld_out    = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	sfr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAX_BODY)
	) u_ram (
		.clk   (clk),
		.we    (body_wr),
		.waddr (cnt_q[AW-1:0]),
		.wdata (rx_byte),
		.raddr (rd_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_HUNT: if (acc_in && flags.eq) state_d = ST_ADDR;
			ST_ADDR: if (acc_in) state_d = flags.eq ? ST_HUNT : ST_LEN;
			ST_LEN:  if (acc_in) state_d = len_bad ? ST_HUNT : ST_BODY;
			ST_BODY: if (acc_in && body_done) state_d = ST_SUM;
			ST_SUM:  if (acc_in) state_d = flags.eq ? ST_END : ST_HUNT;
			ST_END:  if (acc_in) state_d = flags.eq ? ST_RD : ST_HUNT;
			ST_RD:   state_d = ST_EMIT;
			ST_EMIT: if (ld_out) state_d = rd_last ? ST_HUNT : ST_RD;
			default: state_d = ST_HUNT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
			rd_q  <= '0;
		end else begin
			if (acc_in) begin
				case (state_q)
					ST_HUNT: begin
						if (flags.eq) begin
							sum_q <= '0;
							cnt_q <= '0;
						end
					end
					ST_ADDR: if (!flags.eq) sum_q <= alu_sum;
					ST_LEN: begin
						if (!len_bad) begin
							sum_q <= alu_sum;
							cnt_q <= '0;
						end
					end
					ST_BODY: begin
						sum_q <= alu_sum;
						cnt_q <= cnt_nxt;
					end
					ST_END: rd_q <= '0;
					default: ;
				endcase
			end
			if (ld_out) begin
				rd_q <= rd_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in && (state_q == ST_ADDR)) begin
			addr_q <= rx_byte;
		end
		if (acc_in && (state_q == ST_LEN)) begin
			exp_q <= rx_byte[LEN_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			out_addr_q <= addr_q;
			out_len_q  <= exp_q;
			out_byte_q <= ram_rdata;
			last_q     <= rd_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign frame_address = out_addr_q;
	assign body_length   = out_len_q;
	assign body_byte     = out_byte_q;
	assign last          = last_q;

endmodule

/* hw/rtl/sfr_checker.sv */
// ----------------------------------------------------------------------------
// sfr_props
// Port-level checks for the sensor frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module sfr_props (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [sfr_pkg::BYTE_W-1:0] frame_address,
	input logic [sfr_pkg::LEN_W-1:0]  body_length,
	input logic [sfr_pkg::BYTE_W-1:0] body_byte,
	input logic                       last
);
	import sfr_pkg::*;

	// a stalled beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(frame_address) &&
		$stable(body_length) && $stable(body_byte) && $stable(last))
		else $error("output beat changed while stalled");

	a_no_broadcast: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_address != BROADCAST_ADDR)
		else $error("broadcast address frame delivered");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> body_length != '0)
		else $error("zero length frame delivered");

	// mid-burst the parser must not take input
	a_burst_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("input accepted in the middle of a burst");

endmodule

bind sensor_frame_receiver sfr_props u_sfr_props (.*);
